// ----- hdl/swl_pkg.sv -----
package swl_pkg;

  // Session phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_LOAD = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_READY_CODE     = 3'd0,
    CFG_HANDSHAKE_CODE = 3'd1,
    CFG_ACK_CODE       = 3'd2,
    CFG_DONE_ACK_CODE  = 3'd3,
    CFG_END_MARKER     = 3'd4,
    CFG_LOAD_BASE      = 3'd5
  } cfg_idx_t;

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  localparam int ByteW = 8;
  localparam int WordW = 32;
  localparam int PartW = 24;
  localparam int PosW  = 2;
  localparam logic [WordW-1:0] WordStep = 32'd4;

  // Configuration register contents
  typedef struct packed {
    logic [ByteW-1:0] ready_code;
    logic [ByteW-1:0] handshake_code;
    logic [ByteW-1:0] ack_code;
    logic [ByteW-1:0] done_ack_code;
    logic [WordW-1:0] end_marker_word;
    logic [WordW-1:0] load_base_addr;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0] tx_byte;
    logic             write_enable;
    logic [WordW-1:0] write_addr;
    logic [WordW-1:0] write_data;
    logic             load_done;
  } res_t;

endpackage

// ----- hdl/swl_cfg.sv -----
module swl_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swl_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swl_pkg::WordW-1:0]    cfg_data,
  output swl_pkg::cfg_t                cfg
);
  import swl_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg     = cfg_r;

  // Decode the register index; drop writes beyond the list
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_READY_CODE:     cfg_nxt.ready_code     = cfg_data[ByteW-1:0];
        CFG_HANDSHAKE_CODE: cfg_nxt.handshake_code = cfg_data[ByteW-1:0];
        CFG_ACK_CODE:       cfg_nxt.ack_code       = cfg_data[ByteW-1:0];
        CFG_DONE_ACK_CODE:  cfg_nxt.done_ack_code  = cfg_data[ByteW-1:0];
        CFG_END_MARKER:     cfg_nxt.end_marker_word = cfg_data;
        CFG_LOAD_BASE:      cfg_nxt.load_base_addr  = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/swl_core.sv -----
module swl_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [swl_pkg::ByteW-1:0]  in_byte,
  input  swl_pkg::cfg_t              cfg,
  input  logic                       slot_free,
  output logic                       res_valid,
  output swl_pkg::res_t              res
);
  import swl_pkg::*;

  // Input register
  logic             in_valid_r;
  logic             cmd_r;
  logic [ByteW-1:0] byte_r;

  // Session state
  phase_t           phase_r,  phase_nxt;
  logic [PosW-1:0]  pos_r,    pos_nxt;
  logic [PartW-1:0] part_r,   part_nxt;
  logic [WordW-1:0] addr_r,   addr_nxt;

  logic             has_res;
  logic             step;
  logic [WordW-1:0] word;

  assign word = {byte_r, part_r};

  // Work out the result and the next state for the held item
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    part_nxt  = part_r;
    addr_nxt  = addr_r;
    has_res   = 1'b0;
    res       = '0;
    if (cmd_r == CMD_START) begin
      phase_nxt   = PH_WAIT;
      pos_nxt     = '0;
      part_nxt    = '0;
      addr_nxt    = cfg.load_base_addr;
      has_res     = 1'b1;
      res.tx_byte = cfg.ready_code;
    end else begin
      case (phase_r)
        PH_WAIT: begin
          has_res = 1'b1;
          if (byte_r == cfg.handshake_code) begin
            phase_nxt   = PH_LOAD;
            pos_nxt     = '0;
            part_nxt    = '0;
            res.tx_byte = cfg.ack_code;
          end else begin
            res.tx_byte = cfg.ready_code;
          end
        end
        PH_LOAD: begin
          if (pos_r != 2'd3) begin
            // gather a low byte, least significant first
            pos_nxt = pos_r + 2'd1;
            case (pos_r)
              2'd0:    part_nxt[7:0]   = byte_r;
              2'd1:    part_nxt[15:8]  = byte_r;
              default: part_nxt[23:16] = byte_r;
            endcase
          end else begin
            has_res  = 1'b1;
            pos_nxt  = '0;
            part_nxt = '0;
            if (word == cfg.end_marker_word) begin
              phase_nxt     = PH_DONE;
              res.tx_byte   = cfg.done_ack_code;
              res.load_done = 1'b1;
            end else begin
              res.tx_byte      = cfg.ack_code;
              res.write_enable = 1'b1;
              res.write_addr   = addr_r;
              res.write_data   = word;
              addr_nxt         = addr_r + WordStep;
            end
          end
        end
        default: has_res = 1'b0;
      endcase
    end
  end

  // Retire the held item once its result has somewhere to go
  assign step      = in_valid_r && (!has_res || slot_free);
  assign res_valid = step && has_res;
  assign in_ready  = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= PH_IDLE;
      pos_r      <= '0;
      part_r     <= '0;
      addr_r     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (step) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        part_r  <= part_nxt;
        addr_r  <= addr_nxt;
      end
    end
  end

  // Capture payload on each transfer
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r  <= in_cmd;
      byte_r <= in_byte;
    end
  end

endmodule

// ----- hdl/swl_out.sv -----
module swl_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  swl_pkg::res_t  res,
  output logic           slot_free,
  output logic           out_valid,
  input  logic           out_ready,
  output swl_pkg::res_t  out_res
);
  import swl_pkg::*;

  logic out_valid_r;
  res_t out_res_r;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

endmodule

// ----- hdl/serial_word_loader.sv -----
// Serial word loader: the protocol side of a byte-stream boot loader.
// Input channel: in_tuser is the command (0 start a session, 1 byte present),
// in_tdata carries the received byte. Each transfer gives zero or one result.
// Result channel: reply byte for the host, plus an optional word write
// (write_enable, write_addr, write_data) and the load_done flag.
// Configuration channel: cfg_index selects ready, handshake, ack, done-ack
// codes, end marker word and load base address; writes beyond index 5 are
// dropped. Write configuration only while no item is in flight.
// A result passes the input register, then the result register, before it is
// offered on the result channel.
// Throughput: one item per cycle while the result side takes results, set by
// the single combinational pass between those two registers.
// If the receiver stalls, the result register holds its item; the input
// register still takes one more item, and items that produce no result keep
// draining. in_tready falls only when both registers hold a waiting item.
// Reset clears all configuration registers to zero, puts the session in
// idle and empties both registers.
module serial_word_loader (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                   in_tuser,   // [0] command
  // result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [71:0]                  out_tdata,  // [7:0] tx_byte, [39:8] write_addr,
                                                   // [71:40] write_data
  output logic [1:0]                   out_tuser,  // [0] write_enable, [1] load_done
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swl_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swl_pkg::WordW-1:0]    cfg_data
);
  import swl_pkg::*;

  cfg_t cfg;
  logic slot_free;
  logic res_valid;
  res_t res;
  res_t out_res;

  swl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser[0]),
    .in_byte   (in_tdata),
    .cfg       (cfg),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  swl_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result fields, lowest field first
  assign out_tdata = {out_res.write_data, out_res.write_addr, out_res.tx_byte};
  assign out_tuser = {out_res.load_done, out_res.write_enable};

endmodule

// ----- bench/swl_checker.sv -----
module swl_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                   in_tuser,   // [0] command
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [71:0]                  out_tdata,  // [7:0] tx_byte, [39:8] write_addr,
                                                   // [71:40] write_data
  input  logic [1:0]                   out_tuser,  // [0] write_enable, [1] load_done
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [swl_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swl_pkg::WordW-1:0]    cfg_data,
  output int                           fail_count,
  output int                           replies_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import swl_pkg::*;

  // Shadow copy of the loader registers and session
  cfg_t             regs;
  phase_t           session;
  logic [PosW-1:0]  byte_pos;
  logic [PartW-1:0] partial;
  logic [WordW-1:0] next_addr;
  res_t             expected_replies[$];

  // Advance the session by one input transfer; return 1 when a reply is owed
  function automatic bit loader_step(input logic cmd, input logic [ByteW-1:0] b,
                                     output res_t reply);
    logic [WordW-1:0] word;
    reply = '0;
    if (cmd == CMD_START) begin
      session   = PH_WAIT;
      byte_pos  = '0;
      partial   = '0;
      next_addr = regs.load_base_addr;
      reply.tx_byte = regs.ready_code;
      return 1'b1;
    end
    case (session)
      PH_WAIT: begin
        if (b == regs.handshake_code) begin
          session  = PH_LOAD;
          byte_pos = '0;
          partial  = '0;
          reply.tx_byte = regs.ack_code;
        end else begin
          reply.tx_byte = regs.ready_code;
        end
        return 1'b1;
      end
      PH_LOAD: begin
        // Gather the low three bytes, least significant first
        if (byte_pos != '1) begin
          partial  = partial | (PartW'(b) << (ByteW * byte_pos));
          byte_pos = byte_pos + 1'b1;
          return 1'b0;
        end
        word     = {b, partial};
        byte_pos = '0;
        partial  = '0;
        if (word == regs.end_marker_word) begin
          session = PH_DONE;
          reply.tx_byte   = regs.done_ack_code;
          reply.load_done = 1'b1;
        end else begin
          reply.tx_byte      = regs.ack_code;
          reply.write_enable = 1'b1;
          reply.write_addr   = next_addr;
          reply.write_data   = word;
          next_addr          = next_addr + WordStep;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [WordW-1:0] want_v,
                             input logic [WordW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (!rst_n) begin
      regs       = '0;
      session    = PH_IDLE;
      byte_pos   = '0;
      partial    = '0;
      next_addr  = '0;
      fail_count = 0;
      expected_replies.delete();
    end else begin
      // Compare a result transfer with the oldest expectation
      if (out_tvalid && out_tready) begin
        got.tx_byte      = out_tdata[7:0];
        got.write_addr   = out_tdata[39:8];
        got.write_data   = out_tdata[71:40];
        got.write_enable = out_tuser[0];
        got.load_done    = out_tuser[1];
        if (expected_replies.size() == 0) begin
          $error("unexpected result: tx_byte %0h, write_enable %0b, load_done %0b",
                 got.tx_byte, got.write_enable, got.load_done);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("tx_byte", WordW'(want.tx_byte), WordW'(got.tx_byte));
          check_field("write_enable", WordW'(want.write_enable), WordW'(got.write_enable));
          check_field("write_addr", want.write_addr, got.write_addr);
          check_field("write_data", want.write_data, got.write_data);
          check_field("load_done", WordW'(want.load_done), WordW'(got.load_done));
        end
      end

      // Track register writes; drop indexes past the list
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_READY_CODE:     regs.ready_code      = cfg_data[ByteW-1:0];
          CFG_HANDSHAKE_CODE: regs.handshake_code  = cfg_data[ByteW-1:0];
          CFG_ACK_CODE:       regs.ack_code        = cfg_data[ByteW-1:0];
          CFG_DONE_ACK_CODE:  regs.done_ack_code   = cfg_data[ByteW-1:0];
          CFG_END_MARKER:     regs.end_marker_word = cfg_data;
          CFG_LOAD_BASE:      regs.load_base_addr  = cfg_data;
          default: ;
        endcase
      end

      // Predict the reply of an input transfer
      if (in_tvalid && in_tready) begin
        if (loader_step(in_tuser[0], in_tdata, want)) expected_replies.push_back(want);
      end
    end
    replies_pending = expected_replies.size();
  end

endmodule

// ----- bench/tb_serial_word_loader.sv -----
module tb_serial_word_loader;
  timeunit 1ns;
  timeprecision 1ps;
  import swl_pkg::*;

  localparam int ClkHalf       = 5;
  localparam int CycleLimit    = 200000;
  localparam int HoldOffCycles = 80;
  localparam int RandomItems   = 400;
  localparam int SettleCycles  = 6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = CFG_LOAD_BASE + 1'b1;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = '1;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic [7:0]         in_tdata   = '0;
  logic [0:0]         in_tuser   = '0;
  logic               out_tready = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [WordW-1:0]   cfg_data   = '0;
  logic               in_tready;
  logic               out_tvalid;
  logic [71:0]        out_tdata;
  logic [1:0]         out_tuser;
  logic               cfg_ready;

  int   fail_count;
  int   replies_pending;
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  int   hold_off_req = 0;
  int   cycle_count  = 0;
  int   items_sent   = 0;
  cfg_t cur_cfg      = '0;

  serial_word_loader dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  swl_checker loader_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .replies_pending (replies_pending)
  );

  always #ClkHalf clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req != hold_seen) begin
        hold_seen = hold_off_req;
        repeat (HoldOffCycles) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one input item after a random gap; return at the negedge after its transfer
  task automatic send_item(input logic cmd, input logic [ByteW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Send a word as four bytes, least significant first
  task automatic send_word(input logic [WordW-1:0] w);
    for (int i = 0; i < 4; i++) send_item(CMD_BYTE, w[ByteW*i +: ByteW]);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_config(input cfg_t c, input bit with_spare);
    write_reg(CFG_READY_CODE, WordW'(c.ready_code));
    write_reg(CFG_HANDSHAKE_CODE, WordW'(c.handshake_code));
    write_reg(CFG_ACK_CODE, WordW'(c.ack_code));
    write_reg(CFG_DONE_ACK_CODE, WordW'(c.done_ack_code));
    write_reg(CFG_END_MARKER, c.end_marker_word);
    write_reg(CFG_LOAD_BASE, c.load_base_addr);
    // Writes past the register list must change nothing
    if (with_spare) begin
      write_reg(CfgIdxSpareLo, $urandom);
      write_reg(CfgIdxSpareHi, $urandom);
    end
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  // Stop offering, wait out all replies and the pipeline behind them
  task automatic drain;
    in_tvalid <= 1'b0;
    while (replies_pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [WordW-1:0] pick_word;
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // One host session: start, rejected bytes, handshake, words, end marker or abort
  task automatic run_session;
    int n;
    int r;
    logic [ByteW-1:0] b;
    send_item(CMD_START, ByteW'($urandom));
    items_sent++;
    n = $urandom_range(2);
    repeat (n) begin
      b = ByteW'($urandom);
      if (b == cur_cfg.handshake_code) b = ~b;
      send_item(CMD_BYTE, b);
      items_sent++;
    end
    r = $urandom_range(99);
    if (r < 85) begin
      send_item(CMD_BYTE, cur_cfg.handshake_code);
      items_sent++;
      n = $urandom_range(6);
      repeat (n) begin
        send_word(pick_word());
        items_sent += 4;
      end
      if ($urandom_range(99) < 70) begin
        send_word(cur_cfg.end_marker_word);
        items_sent += 4;
        // bytes after the end marker are ignored
        repeat ($urandom_range(2)) send_item(CMD_BYTE, ByteW'($urandom));
      end else begin
        // leave a partial word for the next start to drop
        n = $urandom_range(3);
        repeat (n) begin
          send_item(CMD_BYTE, ByteW'($urandom));
          items_sent++;
        end
      end
    end else begin
      // noise: random commands and bytes
      n = $urandom_range(1, 6);
      repeat (n) begin
        send_item(1'($urandom_range(1)), ByteW'($urandom));
        items_sent++;
      end
    end
  endtask

  initial begin : stimulus
    cfg_t c;
    int target;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: all codes and the end marker are zero
    send_item(CMD_BYTE, 8'hFF);        // ignored while idle
    send_item(CMD_START, 8'h00);
    send_item(CMD_BYTE, 8'h00);        // handshake
    send_word(32'h0000_0000);          // end marker
    drain;

    c = '{ready_code: 8'h00, handshake_code: 8'hFF, ack_code: 8'h80, done_ack_code: 8'h7F,
           end_marker_word: 32'hFFFF_FFFF, load_base_addr: 32'hFFFF_FFFC};
    load_config(c, 1'b1);
    send_item(CMD_START, 8'hFF);
    send_item(CMD_BYTE, 8'h00);        // wrong handshake: ready again
    send_item(CMD_START, 8'h00);       // restart while waiting
    send_item(CMD_BYTE, 8'hFF);
    send_word(32'h0000_0000);          // stored at the top word
    send_word(32'h8000_0001);          // address wraps to zero
    send_item(CMD_BYTE, 8'h55);        // partial word
    send_item(CMD_START, 8'hAA);       // restart drops it
    send_item(CMD_BYTE, 8'hFF);
    send_word(32'hFFFF_FFFF);
    send_item(CMD_BYTE, 8'hFF);        // ignored after done
    drain;

    // Random sessions across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      c.ready_code      = ByteW'($urandom);
      c.handshake_code  = ByteW'($urandom);
      c.ack_code        = ByteW'($urandom);
      c.done_ack_code   = ByteW'($urandom);
      c.end_marker_word = $urandom;
      c.load_base_addr  = $urandom;
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 81;
          stall_pct = 0;
          c.load_base_addr = 32'hFFFF_FFF0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 81;
          c = '1;
        end
        default: begin
          idle_pct  = 18;
          stall_pct = 18;
          c = '0;
        end
      endcase
      load_config(c, ph == 3);
      // hold the result side off while items keep coming
      if (ph == 0) hold_off_req++;
      target = RandomItems * (ph + 1) / 4;
      while (items_sent < target) run_session();
      drain;
    end

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- serial_word_loader.f -----
hdl/swl_pkg.sv
hdl/swl_cfg.sv
hdl/swl_core.sv
hdl/swl_out.sv
hdl/serial_word_loader.sv
bench/swl_checker.sv
bench/tb_serial_word_loader.sv
